FILE: sv/cbpg_pkg.sv
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared types, constants and helper functions of the color bar pattern
// generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int DIM_WIDTH     = $clog2(MAX_DIMENSION) + 1;
   localparam int POS_WIDTH     = $clog2(MAX_DIMENSION);
   localparam int NUM_BARS      = 8;
   localparam int BAR_WIDTH     = $clog2(NUM_BARS);
   localparam int NUM_EDGES     = NUM_BARS - 1;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = DIM_WIDTH;
   localparam int COUNTER_WIDTH   = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_BRIGHTNESS   = 2'd2,
      CSR_MIRROR       = 2'd3
   } csr_index_type;

   localparam logic [DIM_WIDTH-1:0] RESET_FRAME_WIDTH  = DIM_WIDTH'(640);
   localparam logic [DIM_WIDTH-1:0] RESET_FRAME_HEIGHT = DIM_WIDTH'(480);
   localparam logic [7:0]           RESET_BRIGHTNESS   = 8'd128;
   localparam logic [7:0]           NEUTRAL_OFFSET     = 8'd128;

   localparam logic [7:0] BAR_RED   [NUM_BARS] = '{8'd255, 8'd255, 8'd0, 8'd255,
                                                   8'd255, 8'd0,   8'd0, 8'd0};
   localparam logic [7:0] BAR_GREEN [NUM_BARS] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                                   8'd0,   8'd0,   8'd0,   8'd0};
   localparam logic [7:0] BAR_BLUE  [NUM_BARS] = '{8'd255, 8'd0, 8'd255, 8'd0,
                                                   8'd255, 8'd0, 8'd255, 8'd0};

   typedef logic [NUM_EDGES-1:0][DIM_WIDTH-1:0] bar_edges_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] width_last;
      logic [POS_WIDTH-1:0] height_last;
      logic                 width_is_one;
      logic [7:0]           brightness;
      logic                 mirror;
      bar_edges_type        bar_edge;
   } cfg_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0]     column;
      logic [POS_WIDTH-1:0]     row;
      logic [POS_WIDTH-1:0]     source_x;
      logic                     end_of_line;
      logic                     end_of_frame;
      logic                     first_pixel;
      logic                     fourth_byte;
      logic [COUNTER_WIDTH-1:0] frame_counter;
   } pos_type;

   function automatic logic [DIM_WIDTH-1:0] effective_size(input logic [DIM_WIDTH-1:0] v);
      logic [DIM_WIDTH-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_WIDTH'(1);
      end else if (v > DIM_WIDTH'(MAX_DIMENSION)) begin
         r = DIM_WIDTH'(MAX_DIMENSION);
      end
      return r;
   endfunction

   // first column of bars 1..7; all ones when bars are zero wide
   function automatic bar_edges_type bar_edges(input logic [DIM_WIDTH-1:0] w);
      bar_edges_type        e;
      logic [DIM_WIDTH-1:0] bar_w;
      bar_w = w >> BAR_WIDTH;
      for (int k = 0; k < NUM_EDGES; k++) begin
         if (bar_w == '0) begin
            e[k] = '1;
         end else begin
            e[k] = DIM_WIDTH'(bar_w * DIM_WIDTH'(k + 1));
         end
      end
      return e;
   endfunction

endpackage

FILE: sv/cbpg_req_if.sv
// ----------------------------------------------------------------------------
// cbpg_req_if
// Request channel: one transaction per pixel to generate.
// ----------------------------------------------------------------------------
interface cbpg_req_if;
   logic valid;
   logic ready;
   logic stream_start;

   modport source (output valid, output stream_start, input ready);
   modport sink   (input valid, input stream_start, output ready);
endinterface

FILE: sv/cbpg_rsp_if.sv
// ----------------------------------------------------------------------------
// cbpg_rsp_if
// Response channel: one transaction per generated pixel.
// ----------------------------------------------------------------------------
interface cbpg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [11:0] column;
   logic [11:0] row;
   logic        end_of_line;
   logic        end_of_frame;

   modport source (output valid, output red, output green, output blue,
                   output column, output row, output end_of_line,
                   output end_of_frame, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input column, input row, input end_of_line,
                   input end_of_frame, output ready);
endinterface

FILE: sv/cbpg_csr.sv
// ----------------------------------------------------------------------------
// cbpg_csr
// Configuration registers; frame sizes are clamped and bar edges derived
// at write time.
// ----------------------------------------------------------------------------
module cbpg_csr
   import cbpg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   logic [DIM_WIDTH-1:0] width_eff;
   logic [DIM_WIDTH-1:0] height_eff;
   logic [DIM_WIDTH-1:0] reset_width_eff;
   logic [DIM_WIDTH-1:0] reset_height_eff;
   cfg_type              cfg_ff;
   cfg_type              cfg_in;

   always_comb begin
      width_eff        = effective_size(csr_data);
      height_eff       = effective_size(csr_data);
      reset_width_eff  = effective_size(RESET_FRAME_WIDTH);
      reset_height_eff = effective_size(RESET_FRAME_HEIGHT);
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               cfg_in.width_last   = POS_WIDTH'(width_eff - DIM_WIDTH'(1));
               cfg_in.width_is_one = (width_eff == DIM_WIDTH'(1));
               cfg_in.bar_edge     = bar_edges(width_eff);
            end
            CSR_FRAME_HEIGHT: begin
               cfg_in.height_last = POS_WIDTH'(height_eff - DIM_WIDTH'(1));
            end
            CSR_BRIGHTNESS: begin
               cfg_in.brightness = csr_data[7:0];
            end
            CSR_MIRROR: begin
               cfg_in.mirror = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_last   <= POS_WIDTH'(reset_width_eff - DIM_WIDTH'(1));
         cfg_ff.height_last  <= POS_WIDTH'(reset_height_eff - DIM_WIDTH'(1));
         cfg_ff.width_is_one <= (reset_width_eff == DIM_WIDTH'(1));
         cfg_ff.brightness   <= RESET_BRIGHTNESS;
         cfg_ff.mirror       <= 1'b0;
         cfg_ff.bar_edge     <= bar_edges(reset_width_eff);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/cbpg_raster.sv
// ----------------------------------------------------------------------------
// cbpg_raster
// Raster position counters and frame counter; first pipeline stage.
// ----------------------------------------------------------------------------
module cbpg_raster
   import cbpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cbpg_req_if.sink   req,
   input  cfg_type    cfg,
   input  logic       stage_ready,
   output logic       pos_valid,
   output pos_type    pos
);

   logic [POS_WIDTH-1:0]     column_ff, column_in;
   logic [POS_WIDTH-1:0]     row_ff, row_in;
   logic [COUNTER_WIDTH-1:0] frame_counter_ff, frame_counter_in;
   logic                     pos_valid_ff, pos_valid_in;
   pos_type                  pos_ff, pos_in;

   logic                     advance;
   logic                     accept;
   logic [POS_WIDTH-1:0]     col_s, col_a;
   logic [DIM_WIDTH-1:0]     row_s, row_a, row_b;
   logic [COUNTER_WIDTH-1:0] fc_s;
   logic                     eol, eof;

   assign advance   = !pos_valid_ff || stage_ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   always_comb begin
      fc_s  = req.stream_start ? '0 : frame_counter_ff;
      col_s = req.stream_start ? '0 : column_ff;
      row_s = req.stream_start ? '0 : {1'b0, row_ff};
      col_a = col_s;
      row_a = row_s;
      if (col_s > cfg.width_last) begin
         col_a = '0;
         row_a = row_s + DIM_WIDTH'(1);
      end
      row_b = (row_a > {1'b0, cfg.height_last}) ? '0 : row_a;
      eol = (col_a == cfg.width_last);
      eof = eol && (row_b[POS_WIDTH-1:0] == cfg.height_last);

      pos_in.column        = col_a;
      pos_in.row           = row_b[POS_WIDTH-1:0];
      pos_in.source_x      = cfg.mirror ? (cfg.width_last - col_a) : col_a;
      pos_in.end_of_line   = eol;
      pos_in.end_of_frame  = eof;
      pos_in.first_pixel   = (row_b == '0) && (col_a == '0);
      pos_in.fourth_byte   = ((row_b == '0) && (col_a == POS_WIDTH'(1))) ||
                             (cfg.width_is_one && (row_b == DIM_WIDTH'(1)) && (col_a == '0));
      pos_in.frame_counter = fc_s;

      column_in        = column_ff;
      row_in           = row_ff;
      frame_counter_in = frame_counter_ff;
      if (accept) begin
         column_in        = eol ? '0 : col_a + POS_WIDTH'(1);
         row_in           = eof ? '0 :
                            (eol ? row_b[POS_WIDTH-1:0] + POS_WIDTH'(1) : row_b[POS_WIDTH-1:0]);
         frame_counter_in = eof ? fc_s + COUNTER_WIDTH'(1) : fc_s;
      end
      pos_valid_in = advance ? req.valid : pos_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff        <= '0;
         row_ff           <= '0;
         frame_counter_ff <= '0;
         pos_valid_ff     <= 1'b0;
      end else begin
         column_ff        <= column_in;
         row_ff           <= row_in;
         frame_counter_ff <= frame_counter_in;
         pos_valid_ff     <= pos_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= pos_in;
      end
   end

   assign pos_valid = pos_valid_ff;
   assign pos       = pos_ff;

endmodule

FILE: sv/cbpg_color.sv
// ----------------------------------------------------------------------------
// cbpg_color
// Bar lookup, brightness offset, green and blue saturation and frame counter
// insertion; output register.
// ----------------------------------------------------------------------------
module cbpg_color
   import cbpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pos_valid,
   input  pos_type    pos,
   output logic       stage_ready,
   cbpg_rsp_if.source rsp
);

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           red_ff, red_in;
   logic [7:0]           green_ff, green_in;
   logic [7:0]           blue_ff, blue_in;
   logic [POS_WIDTH-1:0] column_ff, row_ff;
   logic                 eol_ff, eof_ff;

   logic [BAR_WIDTH-1:0] bar;
   logic [9:0]           green_sum, blue_sum;
   logic                 load;

   function automatic logic [7:0] saturate(input logic [9:0] biased);
      logic [7:0] r;
      if (biased < 10'd128) begin
         r = 8'd0;
      end else if (biased > 10'd383) begin
         r = 8'd255;
      end else begin
         r = 8'(biased - 10'd128);
      end
      return r;
   endfunction

   assign stage_ready = !out_valid_ff || rsp.ready;
   assign load        = stage_ready && pos_valid;

   always_comb begin
      bar = '0;
      for (int k = 0; k < NUM_EDGES; k++) begin
         bar = bar + BAR_WIDTH'({1'b0, pos.source_x} >= cfg.bar_edge[k]);
      end
      green_sum = {2'b00, BAR_GREEN[bar]} + {2'b00, cfg.brightness};
      blue_sum  = {2'b00, BAR_BLUE[bar]} + {2'b00, cfg.brightness};
      red_in    = BAR_RED[bar] + cfg.brightness + NEUTRAL_OFFSET +
                  {3'b000, pos.frame_counter[4:0]};
      green_in  = saturate(green_sum);
      blue_in   = saturate(blue_sum);
      if (pos.first_pixel) begin
         red_in   = pos.frame_counter[7:0];
         green_in = pos.frame_counter[15:8];
         blue_in  = pos.frame_counter[23:16];
      end else if (pos.fourth_byte) begin
         red_in   = pos.frame_counter[31:24];
      end
      out_valid_in = stage_ready ? pos_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         column_ff <= pos.column;
         row_ff    <= pos.row;
         eol_ff    <= pos.end_of_line;
         eof_ff    <= pos.end_of_frame;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.red          = red_ff;
   assign rsp.green        = green_ff;
   assign rsp.blue         = blue_ff;
   assign rsp.column       = column_ff;
   assign rsp.row          = row_ff;
   assign rsp.end_of_line  = eol_ff;
   assign rsp.end_of_frame = eof_ff;

endmodule

FILE: sv/color_bar_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// color_bar_pattern_generator_unit
// Eight vertical color bar test pattern, one pixel per request in raster
// order.
// ----------------------------------------------------------------------------
// Each request transaction yields one pixel transaction. The block takes a
// request every clock cycle while the response side does not stall: the
// raster and frame counters update in the first stage, the bar lookup and
// color arithmetic fill the output register in the second. Bar boundaries
// are computed when the frame width is written, so no division sits in the
// pixel path. Registers must be written through the csr port only while
// no pixel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module color_bar_pattern_generator_unit
   import cbpg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   cbpg_req_if.sink                   req,
   cbpg_rsp_if.source                 rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type cfg;
   pos_type pos;
   logic    pos_valid;
   logic    stage_ready;

   cbpg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   cbpg_raster u_raster (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .cfg         (cfg),
      .stage_ready (stage_ready),
      .pos_valid   (pos_valid),
      .pos         (pos)
   );

   cbpg_color u_color (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pos_valid   (pos_valid),
      .pos         (pos),
      .stage_ready (stage_ready),
      .rsp         (rsp)
   );

endmodule
